// ===== design/rvx_pkg.sv =====
// Shared types, opcodes, system words and decode helpers for the RV32I executor.
// No dependencies.
package rvx_pkg;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ILLEGAL    = 3'd1,
        ST_MISALIGNED = 3'd2,
        ST_ECALL_U    = 3'd3,
        ST_ECALL_M    = 3'd4,
        ST_BREAK      = 3'd5,
        ST_RETURN     = 3'd6,
        ST_SKIPPED    = 3'd7
    } t_status;

    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [31:0] W_ECALL  = 32'h0000_0073;
    localparam logic [31:0] W_EBREAK = 32'h0010_0073;
    localparam logic [31:0] W_MRET   = 32'h3020_0073;
    localparam logic [31:0] W_SRET   = 32'h1020_0073;
    localparam logic [31:0] W_URET   = 32'h0020_0073;
    localparam logic [31:0] W_WFI    = 32'h1050_0073;

    localparam logic [6:0] F7_ZERO   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_SFENCE = 7'h09;

    function automatic logic [31:0] imm_i(input logic [31:0] w);
        return {{20{w[31]}}, w[31:20]};
    endfunction

    function automatic logic [31:0] imm_s(input logic [31:0] w);
        return {{20{w[31]}}, w[31:25], w[11:7]};
    endfunction

    function automatic logic [31:0] imm_b(input logic [31:0] w);
        return {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
    endfunction

    function automatic logic [31:0] imm_j(input logic [31:0] w);
        return {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
    endfunction

    function automatic logic [31:0] alu_op(input logic [2:0] f3, input logic alt,
                                           input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        case (f3)
            3'd0: r = alt ? a - b : a + b;
            3'd1: r = a << b[4:0];
            3'd2: r = {31'b0, $signed(a) < $signed(b)};
            3'd3: r = {31'b0, a < b};
            3'd4: r = a ^ b;
            3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            3'd6: r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

endpackage

// ===== design/rvx_regfile.sv =====
// 32 x 32 register file, one write and two registered reads, write-first bypass.
// Uses rvx_pkg.
module rvx_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_re,
    input  logic [4:0]  i_ra1,
    input  logic [4:0]  i_ra2,
    input  logic        i_we,
    input  logic [4:0]  i_wa,
    input  logic [31:0] i_wd,
    output logic [31:0] o_rd1,
    output logic [31:0] o_rd2
);
    import rvx_pkg::*;

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_rd1;
    logic [31:0] r_rd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && i_wa == i_ra1) r_rd1 <= i_wd;
            else r_rd1 <= r_vld[i_ra1] ? r_mem[i_ra1] : '0;
            if (i_we && i_wa == i_ra2) r_rd2 <= i_wd;
            else r_rd2 <= r_vld[i_ra2] ? r_mem[i_ra2] : '0;
        end
    end

    assign o_rd1 = r_rd1;
    assign o_rd2 = r_rd2;

endmodule

// ===== design/rvx_dmem.sv =====
// Data store as four byte lanes of synchronous RAM with a clearing pass after reset.
// Uses rvx_pkg.
module rvx_dmem #(
    parameter int ROWS = 1024,
    parameter int RW   = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [3:0]           i_we,
    input  logic [3:0][RW-1:0]   i_row,
    input  logic [3:0][7:0]      i_wdata,
    output logic [3:0][7:0]      o_rdata,
    output logic                 o_busy
);
    import rvx_pkg::*;

    logic          r_busy;
    logic [RW-1:0] r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            if (r_clr_row == RW'(ROWS - 1)) r_busy <= 1'b0;
            else r_clr_row <= r_clr_row + 1'b1;
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [7:0] r_mem [ROWS];
        logic [7:0] r_rd;
        always_ff @(posedge i_clk) begin
            if (r_busy) r_mem[r_clr_row] <= '0;
            else if (i_we[l]) r_mem[i_row[l]] <= i_wdata[l];
            r_rd <= r_mem[i_row[l]];
        end
        assign o_rdata[l] = r_rd;
    end

    assign o_busy = r_busy;

endmodule

// ===== design/rv32i_instruction_executor_unit.sv =====
// RV32I executor: one result item per instruction item.
// An item is registered for execute, its result at the output; a load adds a
// data lane read phase. Throughput: 1 item per cycle unless the output stalls
// or a load waits on its read; the register file bypass lets dependent items
// follow back to back. Reset: registers and PC zero, machine mode set; the
// data store clear pass covers DATA_BYTES/4 rows; no item is accepted then.
module rv32i_instruction_executor_unit #(
    parameter int DATA_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instruction_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_pc_after,
    output logic        o_dest_written,
    output logic [4:0]  o_dest_index,
    output logic [31:0] o_dest_value
);
    import rvx_pkg::*;

    localparam int ROWS = DATA_BYTES / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic        r_mmode;
    logic [31:0] r_pc;
    logic        r_ex_valid;
    logic        r_phase;
    logic [31:0] r_ex_word;
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [31:0] r_pc_after;
    logic        r_dw;
    logic [4:0]  r_di;
    logic [31:0] r_dv;

    logic [31:0] a, b;
    logic        accept, fire, out_free, ld_go, dm_busy;
    t_status     status;
    logic [31:0] nxt, wv, maddr, tgt, ldv, pc_new;
    logic        wr, dwr;
    logic [3:0]         dm_we;
    logic [3:0][RW-1:0] dm_row;
    logic [3:0][7:0]    dm_wdata, dm_rdata;

    wire [6:0] opc = r_ex_word[6:0];
    wire [4:0] rd  = r_ex_word[11:7];
    wire [2:0] f3  = r_ex_word[14:12];
    wire [6:0] f7  = r_ex_word[31:25];

    rvx_regfile u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_re(accept),
        .i_ra1(i_instruction_word[19:15]), .i_ra2(i_instruction_word[24:20]),
        .i_we(fire && dwr), .i_wa(rd), .i_wd(wv),
        .o_rd1(a), .o_rd2(b)
    );

    rvx_dmem #(.ROWS(ROWS), .RW(RW)) u_dm (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_we(dm_we), .i_row(dm_row), .i_wdata(dm_wdata),
        .o_rdata(dm_rdata), .o_busy(dm_busy)
    );

    always_comb begin
        logic [1:0]  li;
        logic [31:0] s;
        logic        en;
        maddr = a + ((opc == OP_STORE) ? imm_s(r_ex_word) : imm_i(r_ex_word));
        for (int l = 0; l < 4; l++) begin
            li = 2'(l) - maddr[1:0];
            s  = maddr + {30'b0, li};
            dm_row[l] = RW'(s[31:2] & 30'(ROWS - 1));
            case (f3[1:0])
                2'd0:    en = (li == 2'd0);
                2'd1:    en = !li[1];
                default: en = 1'b1;
            endcase
            dm_we[l]    = fire && opc == OP_STORE && status == ST_OK && en;
            dm_wdata[l] = 8'(b >> {li, 3'b000});
        end
    end

    always_comb begin
        logic [3:0][7:0] lb;
        for (int i = 0; i < 4; i++) lb[i] = dm_rdata[2'(i) + maddr[1:0]];
        case (f3[1:0])
            2'd0:    ldv = {{24{lb[0][7] & !f3[2]}}, lb[0]};
            2'd1:    ldv = {{16{lb[1][7] & !f3[2]}}, lb[1], lb[0]};
            default: ldv = lb;
        endcase
    end

    always_comb begin
        logic take;
        status = ST_OK;
        nxt    = r_pc + 32'd4;
        wr     = 1'b0;
        wv     = '0;
        tgt    = '0;
        take   = 1'b0;
        case (opc)
            OP_LOAD: begin
                if (f3[1:0] == 2'b11 || f3 == 3'd6) status = ST_ILLEGAL;
                else begin wr = 1'b1; wv = ldv; end
            end
            OP_FENCE: ;
            OP_IMM: begin
                if ((f3 == 3'd1 && f7 != F7_ZERO) ||
                    (f3 == 3'd5 && f7 != F7_ZERO && f7 != F7_ALT)) status = ST_ILLEGAL;
                else begin
                    wr = 1'b1;
                    wv = alu_op(f3, f3 == 3'd5 && r_ex_word[30], a, imm_i(r_ex_word));
                end
            end
            OP_AUIPC: begin wr = 1'b1; wv = r_pc + {r_ex_word[31:12], 12'b0}; end
            OP_STORE: if (f3 > 3'd2) status = ST_ILLEGAL;
            OP_REG: begin
                if (!(f7 == F7_ZERO || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))))
                    status = ST_ILLEGAL;
                else begin wr = 1'b1; wv = alu_op(f3, f7 == F7_ALT, a, b); end
            end
            OP_LUI: begin wr = 1'b1; wv = {r_ex_word[31:12], 12'b0}; end
            OP_BRANCH: begin
                if (f3 == 3'd2 || f3 == 3'd3) status = ST_ILLEGAL;
                else begin
                    if (f3[2]) take = f3[1] ? (a < b) : ($signed(a) < $signed(b));
                    else take = (a == b);
                    if (f3[0]) take = !take;
                    tgt = r_pc + imm_b(r_ex_word);
                    if (take) begin
                        if (tgt[1:0] != 2'b00) status = ST_MISALIGNED;
                        else nxt = tgt;
                    end
                end
            end
            OP_JALR: begin
                tgt = (a + imm_i(r_ex_word)) & 32'hFFFF_FFFE;
                if (f3 != 3'd0) status = ST_ILLEGAL;
                else if (tgt[1:0] != 2'b00) status = ST_MISALIGNED;
                else begin wr = 1'b1; wv = r_pc + 32'd4; nxt = tgt; end
            end
            OP_JAL: begin
                tgt = r_pc + imm_j(r_ex_word);
                if (tgt[1:0] != 2'b00) status = ST_MISALIGNED;
                else begin wr = 1'b1; wv = r_pc + 32'd4; nxt = tgt; end
            end
            OP_SYSTEM: begin
                if (r_ex_word == W_ECALL) status = r_mmode ? ST_ECALL_M : ST_ECALL_U;
                else if (r_ex_word == W_EBREAK) status = ST_BREAK;
                else if (r_ex_word == W_MRET) status = r_mmode ? ST_RETURN : ST_ILLEGAL;
                else if (r_ex_word == W_SRET || r_ex_word == W_URET || r_ex_word == W_WFI)
                    status = ST_ILLEGAL;
                else if (f3 == 3'd0) status = (f7 == F7_SFENCE) ? ST_SKIPPED : ST_ILLEGAL;
                else if (f3 == 3'd4) status = ST_ILLEGAL;
                else status = ST_SKIPPED;
            end
            default: status = ST_ILLEGAL;
        endcase
        dwr    = wr && status == ST_OK && rd != 5'd0;
        pc_new = (status inside {ST_OK, ST_BREAK, ST_SKIPPED}) ? nxt : r_pc;
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign ld_go      = !r_phase && opc == OP_LOAD && status == ST_OK;
    assign fire       = r_ex_valid && out_free && !ld_go;
    assign o_in_stall = dm_busy || (r_ex_valid && !fire);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mmode     <= 1'b1;
            r_pc        <= '0;
            r_ex_valid  <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_mmode <= i_cfg_wdata;
            if (r_ex_valid && ld_go) r_phase <= 1'b1;
            else if (fire) r_phase <= 1'b0;
            if (accept) r_ex_valid <= 1'b1;
            else if (fire) r_ex_valid <= 1'b0;
            if (fire) begin
                r_pc        <= pc_new;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_ex_word <= i_instruction_word;
        if (fire) begin
            r_status   <= status;
            r_pc_after <= pc_new;
            r_dw       <= dwr;
            r_di       <= dwr ? rd : 5'd0;
            r_dv       <= dwr ? wv : 32'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_pc_after     = r_pc_after;
    assign o_dest_written = r_dw;
    assign o_dest_index   = r_di;
    assign o_dest_value   = r_dv;

    a_phase_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_ex_valid)
        else $error("load second cycle without a held item");
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dm_busy |-> o_in_stall && !fire)
        else $error("item taken during data store clear");
    a_dest_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dest_written |-> o_dest_index != 5'd0)
        else $error("write reported to x0");
    a_load_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex_valid && ld_go |=> r_phase && r_ex_valid)
        else $error("load did not move to its data cycle");
    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_pc))
        else $error("pc moved without a result");

endmodule

// ===== verif/rv32i_instruction_executor_unit_checker.sv =====
// Checker for the RV32I executor: watches both channels, runs an instruction-level
// predictor over accepted instructions and compares every result item.
// Depends on rvx_pkg for status codes, opcodes and system words.
module rv32i_instruction_executor_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_instruction_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_pc_after,
    input  logic        i_dest_written,
    input  logic [4:0]  i_dest_index,
    input  logic [31:0] i_dest_value,
    output int          o_fail_count,
    output int          o_pending
);
    import rvx_pkg::*;

    localparam int MEM_BYTES = 4096;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pc_after;
        logic        dest_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
    } t_retire;

    logic [31:0] gpr [32];
    logic [7:0]  dmem [MEM_BYTES];
    logic [31:0] pc;
    logic        mach;
    t_retire     retire_q[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = retire_q.size();

    function automatic logic [31:0] rdreg(input logic [4:0] idx);
        return idx == 5'd0 ? 32'd0 : gpr[idx];
    endfunction

    function automatic logic [31:0] sext_i(input logic [31:0] w);
        return {{20{w[31]}}, w[31:20]};
    endfunction

    function automatic logic [31:0] calc(input logic [2:0] f3, input logic alt,
                                         input logic [31:0] a, input logic [31:0] b);
        logic [4:0]  sh;
        logic [31:0] r;
        sh = b[4:0];
        case (f3)
            3'd0: r = alt ? a - b : a + b;
            3'd1: r = a << sh;
            3'd2: r = {31'd0, (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000)};
            3'd3: r = {31'd0, a < b};
            3'd4: r = a ^ b;
            3'd5: begin
                r = a >> sh;
                if (alt && a[31]) r = r | ~(32'hFFFF_FFFF >> sh);
            end
            3'd6: r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

    task automatic execute(input logic [31:0] w);
        logic [31:0] nxt, a, b, addr, v, wv, imm;
        logic [2:0]  f3, st;
        logic [6:0]  f7;
        logic [4:0]  rd;
        logic        wr, take;
        int          n;
        t_retire     r;
        nxt = pc + 4; st = ST_OK; wr = 0; wv = 0;
        rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
        a = rdreg(w[19:15]); b = rdreg(w[24:20]);
        case (w[6:0])
            OP_LOAD: begin
                if (f3[1:0] == 2'd3 || f3 == 3'd6) st = ST_ILLEGAL;
                else begin
                    n = 1 << f3[1:0];
                    addr = a + sext_i(w);
                    v = 0;
                    for (int k = 0; k < n; k++)
                        v |= 32'(dmem[(addr + k) % MEM_BYTES]) << (8 * k);
                    if (!f3[2] && n < 4 && v[8 * n - 1]) v |= 32'hFFFF_FFFF << (8 * n);
                    wr = 1; wv = v;
                end
            end
            OP_FENCE: ;
            OP_IMM: begin
                if (f3 == 3'd1 && f7 != F7_ZERO) st = ST_ILLEGAL;
                else if (f3 == 3'd5 && f7 != F7_ZERO && f7 != F7_ALT) st = ST_ILLEGAL;
                else begin
                    wr = 1; wv = calc(f3, f3 == 3'd5 && w[30], a, sext_i(w));
                end
            end
            OP_AUIPC: begin wr = 1; wv = pc + {w[31:12], 12'd0}; end
            OP_STORE: begin
                if (f3 > 3'd2) st = ST_ILLEGAL;
                else begin
                    n = 1 << f3;
                    addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
                    for (int k = 0; k < n; k++)
                        dmem[(addr + k) % MEM_BYTES] = b[8 * k +: 8];
                end
            end
            OP_REG: begin
                if (!(f7 == F7_ZERO || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))))
                    st = ST_ILLEGAL;
                else begin wr = 1; wv = calc(f3, f7 == F7_ALT, a, b); end
            end
            OP_LUI: begin wr = 1; wv = {w[31:12], 12'd0}; end
            OP_BRANCH: begin
                if (f3 == 3'd2 || f3 == 3'd3) st = ST_ILLEGAL;
                else begin
                    if (f3[2]) take = f3[1] ? (a < b)
                                            : ((a ^ 32'h8000_0000) < (b ^ 32'h8000_0000));
                    else take = (a == b);
                    if (f3[0]) take = !take;
                    if (take) begin
                        imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                        addr = pc + imm;
                        if (addr[1:0] != 0) st = ST_MISALIGNED; else nxt = addr;
                    end
                end
            end
            OP_JALR: begin
                if (f3 != 0) st = ST_ILLEGAL;
                else begin
                    addr = (a + sext_i(w)) & 32'hFFFF_FFFE;
                    if (addr[1:0] != 0) st = ST_MISALIGNED;
                    else begin wr = 1; wv = pc + 4; nxt = addr; end
                end
            end
            OP_JAL: begin
                imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                addr = pc + imm;
                if (addr[1:0] != 0) st = ST_MISALIGNED;
                else begin wr = 1; wv = pc + 4; nxt = addr; end
            end
            OP_SYSTEM: begin
                if (w == W_ECALL) st = mach ? ST_ECALL_M : ST_ECALL_U;
                else if (w == W_EBREAK) st = ST_BREAK;
                else if (w == W_MRET) st = mach ? ST_RETURN : ST_ILLEGAL;
                else if (w == W_SRET || w == W_URET || w == W_WFI) st = ST_ILLEGAL;
                else if (f3 == 3'd0) st = (f7 == F7_SFENCE) ? ST_SKIPPED : ST_ILLEGAL;
                else if (f3 == 3'd4) st = ST_ILLEGAL;
                else st = ST_SKIPPED;
            end
            default: st = ST_ILLEGAL;
        endcase
        if (st != ST_OK) wr = 0;
        if (st == ST_OK || st == ST_BREAK || st == ST_SKIPPED) pc = nxt;
        if (wr && rd != 0) gpr[rd] = wv;
        else begin wr = 0; rd = 0; wv = 0; end
        r.status = st; r.pc_after = pc; r.dest_written = wr;
        r.dest_index = rd; r.dest_value = wv;
        retire_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_retire exp_r;
        if (!i_rst_n) begin
            foreach (gpr[k]) gpr[k] = 0;
            foreach (dmem[k]) dmem[k] = 0;
            pc = 0; mach = 1; fails = 0;
            retire_q.delete();
        end else begin
            if (i_cfg_we) mach = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (retire_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result item, status %0d", i_status);
                end else begin
                    exp_r = retire_q.pop_front();
                    if (exp_r.status !== i_status || exp_r.pc_after !== i_pc_after ||
                        exp_r.dest_written !== i_dest_written ||
                        exp_r.dest_index !== i_dest_index ||
                        exp_r.dest_value !== i_dest_value) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp st %0d pc %h wr %0d rd %0d v %h",
                                     " / got st %0d pc %h wr %0d rd %0d v %h",
                                     exp_r.status, exp_r.pc_after, exp_r.dest_written,
                                     exp_r.dest_index, exp_r.dest_value, i_status,
                                     i_pc_after, i_dest_written, i_dest_index,
                                     i_dest_value);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) execute(i_instruction_word);
        end
    end
endmodule

// ===== verif/rv32i_instruction_executor_unit_test.sv =====
// Top of the RV32I executor testbench: clock, reset, instruction stimulus,
// output stall pattern, mode writes and verdict. Depends on rvx_pkg and the checker.
module rv32i_instruction_executor_unit_test;
    import rvx_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_wdata = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [31:0] instr = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  status;
    logic [31:0] pc_after;
    logic        dest_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          calm = 0;
    bit          hold_out = 0;

    always #5 clk = ~clk;

    rv32i_instruction_executor_unit #(.DATA_BYTES(4096)) uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_instruction_word(instr),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_status(status),
        .o_pc_after(pc_after), .o_dest_written(dest_written),
        .o_dest_index(dest_index), .o_dest_value(dest_value)
    );

    rv32i_instruction_executor_unit_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_instruction_word(instr),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_pc_after(pc_after), .i_dest_written(dest_written),
        .i_dest_index(dest_index), .i_dest_value(dest_value),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: cycles with no item accepted and no result taken
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // output stall: random bursts, or a long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_out) begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                hold_out = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 14);
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end else begin
                out_stall <= 0;
                @(posedge clk);
            end
        end
    end

    task automatic send(input logic [31:0] w);
        in_valid <= 1;
        instr <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic gap();
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 14);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        drain();
        cfg_we <= 1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [4:0] rsel();
        return $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
    endfunction

    // mostly well-formed instructions with random content, some raw noise
    function automatic logic [31:0] gen_instr();
        logic [31:0] w;
        logic [6:0]  opc;
        int          sel;
        logic [6:0]  ops [11];
        ops = '{OP_LOAD, OP_FENCE, OP_IMM, OP_AUIPC, OP_STORE, OP_REG, OP_LUI,
                OP_BRANCH, OP_JALR, OP_JAL, OP_SYSTEM};
        sel = $urandom_range(0, 99);
        w = $urandom;
        if (sel < 8) return w;
        opc = ops[$urandom_range(0, 10)];
        if (sel < 35) opc = (sel < 20) ? OP_IMM : OP_REG;
        else if (sel < 55) opc = (sel < 45) ? OP_LOAD : OP_STORE;
        w[6:0] = opc;
        w[11:7] = rsel();
        w[19:15] = rsel();
        w[24:20] = rsel();
        case (opc)
            OP_REG: if ($urandom_range(0, 9) != 0)
                w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
            OP_IMM: if (w[13:12] == 2'b01 && $urandom_range(0, 9) != 0)
                w[31:25] = w[14] && $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
            OP_LOAD, OP_STORE: if ($urandom_range(0, 3) != 0) begin
                w[14:12] = opc == OP_LOAD ? 3'($urandom_range(0, 5))
                                          : 3'($urandom_range(0, 2));
                if (w[14:12] == 3'd3) w[14:12] = 3'd4;
                w[31:25] = $urandom_range(0, 1) ? 7'h7F : 7'h00;
            end
            OP_BRANCH, OP_JAL: if ($urandom_range(0, 3) != 0) begin
                w[8] = 0;
                w[24:21] = $urandom_range(0, 1) ? 4'hF : 4'h0;
                w[30:25] = 0; w[19:12] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                if (opc == OP_JAL) w[31] = w[19];
            end
            OP_JALR: if ($urandom_range(0, 3) != 0) w[14:12] = 0;
            OP_SYSTEM: if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 5))
                    0: w = W_ECALL; 1: w = W_EBREAK; 2: w = W_MRET;
                    3: w = W_SRET;  4: w = W_URET;   default: w = W_WFI;
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        logic [31:0] dir [$];
        rst_n <= 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: ALU, memory, jumps, system words, extremes
        dir = '{32'h0010_0093, 32'hFFF0_0113, 32'h0020_81B3, 32'h4020_81B3,
                32'h4010_D213, 32'h01F1_5293, 32'hFFFF_F337, 32'h0000_0397,
                32'h0020_A023, 32'hFE20_9FA3, 32'h0000_2403, 32'hFFF0_4483,
                32'h0000_000F, 32'h0020_8463, 32'h0000_0663, 32'h0080_006F,
                32'h0010_0567, 32'h0000_0067, W_ECALL, W_EBREAK, W_MRET, W_WFI,
                32'h3000_2073, 32'h1200_0073, 32'hFFFF_FFFF};
        foreach (dir[k]) send(dir[k]);
        set_mode(0);
        send(W_ECALL); send(W_MRET); send(32'h0000_0000);
        set_mode(1);

        for (int k = 0; k < 1450; k++) begin
            if (k == 300) hold_out = 1;
            if (k == 700) drain();
            if (k == 500) set_mode(0);
            if (k == 900) set_mode(1);
            if (k == 1200) calm = 1;
            send(gen_instr());
            gap();
        end
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
